FILE: src/pfa_pkg.sv
package pfa_pkg;

	// Default geometry
	localparam int NUM_FRAMES_DEF = 65536;
	localparam int PAGE_SHIFT_DEF = 12;

	// Field widths
	localparam int ADDR_W    = 32;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 3;
	localparam int REF_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Operation kinds
	localparam logic [KIND_W-1:0] KIND_FREE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INC   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DEC   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADFREE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	// Saturation point of a reference count
	localparam logic [REF_W-1:0] REF_MAX = 7'd127;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHYS_TOP   = 2'd1;
	localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h0010_0000;
	localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 32'h0E00_0000;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
	} dp_stat_t;

endpackage

FILE: src/pfa_ram.sv
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/pfa_ctrl.sv
module pfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pfa_pkg::dp_stat_t stat,
	output pfa_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	import pfa_pkg::*;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands
	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.accept = (state_q == S_IDLE) && start;
	assign cmd.exec   = (state_q == S_EXEC);
	assign busy       = (state_q != S_IDLE);

`ifndef SYNTH
	// an accepted item is executed in the very next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.exec)
		else $error("accepted item not executed");

	// the clearing pass is only left at its last entry
	a_clear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear && !stat.clear_last) |=> cmd.clear)
		else $error("clearing pass left early");

	// execute lasts one cycle and returns to idle
	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !busy)
		else $error("execute did not return to idle");
`endif

endmodule

FILE: src/pfa_dp.sv
module pfa_dp #(
	parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfa_pkg::dp_cmd_t                 cmd,
	output pfa_pkg::dp_stat_t                stat,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfa_pkg::ADDR_W-1:0]       cfg_data,
	input  logic [pfa_pkg::KIND_W-1:0]       kind,
	input  logic [pfa_pkg::ADDR_W-1:0]       phys_addr,
	output logic                             done,
	output logic [pfa_pkg::STATUS_W-1:0]     status,
	output logic [pfa_pkg::ADDR_W-1:0]       alloc_addr,
	output logic [pfa_pkg::REF_W-1:0]        ref_count
);

	import pfa_pkg::*;

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);

	// Registers
	logic [ADDR_W-1:0]   kend_q, ptop_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CNT_W-1:0]    fc_q;
	logic [FRAME_W-1:0]  clr_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   alloc_addr_q;
	logic [REF_W-1:0]    ref_count_q;

	// Datapath nets
	logic [ADDR_W-1:0]   in_frame, frame32;
	logic                in_range, aligned;
	logic [CNT_W-1:0]    fc_dec;
	logic [FRAME_W-1:0]  stack_rdata;
	logic [REF_W-1:0]    ref_rdata;
	logic                push, pop, ref_we_x;
	logic [FRAME_W-1:0]  ref_wa_x;
	logic [REF_W-1:0]    ref_wd_x;
	logic [STATUS_W-1:0] status_d;
	logic [ADDR_W-1:0]   alloc_d;
	logic [REF_W-1:0]    count_d;
	logic                ref_we;
	logic [FRAME_W-1:0]  ref_wa;
	logic [REF_W-1:0]    ref_wd;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q <= KERNEL_END_RST;
			ptop_q <= PHYS_TOP_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_KERNEL_END) begin
				kend_q <= cfg_data;
			end
			if (cfg_index == REG_PHYS_TOP) begin
				ptop_q <= cfg_data;
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			addr_q <= phys_addr;
		end
	end

	// Address decode
	assign in_frame = phys_addr >> PAGE_SHIFT;
	assign frame32  = addr_q >> PAGE_SHIFT;
	assign in_range = frame32 < ADDR_W'(NUM_FRAMES);
	assign aligned  = (addr_q[PAGE_SHIFT-1:0] == '0);
	assign fc_dec   = fc_q - CNT_W'(1);

	// Free stack: read top at accept, push during execute
	pfa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_stack (
		.clk   (clk),
		.we    (cmd.exec && push),
		.waddr (fc_q[FRAME_W-1:0]),
		.wdata (frame32[FRAME_W-1:0]),
		.raddr (fc_dec[FRAME_W-1:0]),
		.rdata (stack_rdata)
	);

	// Reference counts: read at accept, write during execute or clear
	pfa_ram #(.WIDTH(REF_W), .DEPTH(NUM_FRAMES)) u_refs (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_wa),
		.wdata (ref_wd),
		.raddr (in_frame[FRAME_W-1:0]),
		.rdata (ref_rdata)
	);

	// Operation decode and checks
	always_comb begin
		status_d = ST_OK;
		alloc_d  = '0;
		count_d  = '0;
		push     = 1'b0;
		pop      = 1'b0;
		ref_we_x = 1'b0;
		ref_wa_x = frame32[FRAME_W-1:0];
		ref_wd_x = '0;
		case (kind_q)
			KIND_FREE: begin
				if (!aligned || addr_q < kend_q || addr_q >= ptop_q) begin
					status_d = ST_BADFREE;
				end else if (!in_range) begin
					status_d = ST_RANGE;
				end else if (fc_q >= CNT_W'(NUM_FRAMES)) begin
					status_d = ST_FULL;
				end else begin
					push = 1'b1;
				end
			end
			KIND_ALLOC: begin
				if (fc_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pop      = 1'b1;
					ref_we_x = 1'b1;
					ref_wa_x = stack_rdata;
					alloc_d  = ADDR_W'(stack_rdata) << PAGE_SHIFT;
				end
			end
			KIND_INC: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else if (ref_rdata < REF_MAX) begin
					ref_we_x = 1'b1;
					ref_wd_x = ref_rdata + REF_W'(1);
				end
			end
			KIND_DEC: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else if (ref_rdata == '0) begin
					status_d = ST_UNDERFLOW;
				end else begin
					ref_we_x = 1'b1;
					ref_wd_x = ref_rdata - REF_W'(1);
				end
			end
			KIND_READ: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					count_d = ref_rdata;
				end
			end
			KIND_CLEAR: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					ref_we_x = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Count RAM write port: clearing pass has priority
	always_comb begin
		if (cmd.clear) begin
			ref_we = 1'b1;
			ref_wa = clr_q;
			ref_wd = '0;
		end else begin
			ref_we = cmd.exec && ref_we_x;
			ref_wa = ref_wa_x;
			ref_wd = ref_wd_x;
		end
	end

	// Clear sweep counter and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			fc_q  <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + FRAME_W'(1);
			end
			if (cmd.exec && push) begin
				fc_q <= fc_q + CNT_W'(1);
			end else if (cmd.exec && pop) begin
				fc_q <= fc_dec;
			end
		end
	end

	assign stat.clear_last = (clr_q == FRAME_W'(NUM_FRAMES - 1));

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= status_d;
			alloc_addr_q <= alloc_d;
			ref_count_q  <= count_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign alloc_addr = alloc_addr_q;
	assign ref_count  = ref_count_q;

`ifndef SYNTH
	// stack depth never passes the frame count
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CNT_W'(NUM_FRAMES))
		else $error("free count overflow");

	// a good allocate pops exactly one entry
	a_alloc_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && kind_q == KIND_ALLOC && status_q == ST_OK) |->
		(fc_q == $past(fc_q) - CNT_W'(1)))
		else $error("allocate did not pop");

	// only allocate returns an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && kind_q != KIND_ALLOC) |-> (alloc_addr_q == '0))
		else $error("address on non-allocate item");

	// only a count read returns a count
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && kind_q != KIND_READ) |-> (ref_count_q == '0))
		else $error("count on non-read item");
`endif

endmodule

FILE: src/page_frame_allocator_refcount.sv
// Channel   Handshake                  Payload
// --------  -------------------------  ----------------------------------
// command   start / busy               kind, phys_addr
// result    done (one-cycle strobe)    status, alloc_addr, ref_count
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// The accept edge reads the stack top and the frame's count from RAM,
// the next cycle checks and writes back, and done pulses in the cycle
// after that. busy is high in the execute state and the clearing pass,
// so a new item may be accepted while done is high. After reset a
// clearing pass zeroes the count RAM with busy high; cfg writes are
// taken during it. The result side cannot stall.
module page_frame_allocator_refcount #(
	parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pfa_pkg::KIND_W-1:0]    kind,
	input  logic [pfa_pkg::ADDR_W-1:0]    phys_addr,
	output logic                          done,
	output logic [pfa_pkg::STATUS_W-1:0]  status,
	output logic [pfa_pkg::ADDR_W-1:0]    alloc_addr,
	output logic [pfa_pkg::REF_W-1:0]     ref_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfa_pkg::ADDR_W-1:0]    cfg_data
);

	import pfa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer
	pfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Stack, count table and result registers
	pfa_dp #(.NUM_FRAMES(NUM_FRAMES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kind       (kind),
		.phys_addr  (phys_addr),
		.done       (done),
		.status     (status),
		.alloc_addr (alloc_addr),
		.ref_count  (ref_count)
	);

endmodule
